// ----- src/tga_rle_pixel_decoder_macros.svh -----
// assertion macros for the decoder rtl
// no dependencies, included by the top level
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TRPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trpd check failed");

// next-cycle implication, checked outside reset
`define TRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trpd check failed");

`endif

// ----- src/trpd_pkg.sv -----
// shared types and constants for the tga rle pixel decoder
// no dependencies
`default_nettype none

package trpd_pkg;

    localparam int DATA_W          = 8;
    localparam int PIXEL_W         = 32;
    localparam int GATHER_W        = 24;
    localparam int COUNT_W         = 8;
    localparam int BPP_W           = 3;
    localparam int PIXEL_TOTAL_W   = 24;
    localparam int BYTE_IDX_W      = 2;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 4;
    localparam int PIXEL_COUNT_BITS_DEF = 24;

    localparam logic [BPP_W-1:0]         BPP_MIN        = 3'd1;
    localparam logic [BPP_W-1:0]         BPP_MAX        = 3'd4;
    localparam logic [DATA_W-1:0]        RUN_BIAS       = 8'd127;
    localparam logic [DATA_W-1:0]        RUN_THRESHOLD  = 8'd128;
    localparam logic                     RLE_MODE_RST   = 1'b1;
    localparam logic [BPP_W-1:0]         BPP_RST        = 3'd4;
    localparam logic [PIXEL_TOTAL_W-1:0] PIXEL_TOTAL_RST = 24'd1;

    typedef enum logic [1:0] {
        REG_RLE_MODE    = 2'd0,
        REG_BPP         = 2'd1,
        REG_PIXEL_TOTAL = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                     rle_mode;
        logic [BPP_W-1:0]         bytes_per_pixel;
        logic [PIXEL_TOTAL_W-1:0] pixel_total;
        logic                     restart;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_done;
    } t_result;

    typedef struct packed {
        logic finished;
        logic left_zero;
        logic phase_header;
        logic packet_left_zero;
    } t_core_stat;

endpackage

`default_nettype wire

// ----- src/trpd_cfg_regs.sv -----
// apb register bank: mode, bytes per pixel, pixel total, restart pulse
// depends on trpd_pkg
`default_nettype none

module trpd_cfg_regs import trpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic                     r_rle_mode;
    logic [BPP_W-1:0]         r_bpp;
    logic [PIXEL_TOTAL_W-1:0] r_pixel_total;
    logic                     r_restart;
    logic                     wr_en;
    t_reg_idx                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode    <= RLE_MODE_RST;
            r_bpp         <= BPP_RST;
            r_pixel_total <= PIXEL_TOTAL_RST;
            r_restart     <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (wr_en) begin
                unique case (reg_idx)
                    REG_RLE_MODE: begin
                        r_rle_mode <= pwdata[0];
                        r_restart  <= 1'b1;
                    end
                    REG_BPP: begin
                        r_bpp     <= pwdata[BPP_W-1:0];
                        r_restart <= 1'b1;
                    end
                    REG_PIXEL_TOTAL: begin
                        r_pixel_total <= pwdata[PIXEL_TOTAL_W-1:0];
                        r_restart     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_RLE_MODE:    prdata = APB_DATA_W'(r_rle_mode);
            REG_BPP:         prdata = APB_DATA_W'(r_bpp);
            REG_PIXEL_TOTAL: prdata = APB_DATA_W'(r_pixel_total);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.rle_mode        = r_rle_mode;
    assign o_cfg.bytes_per_pixel = r_bpp;
    assign o_cfg.pixel_total     = r_pixel_total;
    assign o_cfg.restart         = r_restart;

endmodule

`default_nettype wire

// ----- src/trpd_core.sv -----
// input byte reg, packet/pixel state; one byte per cycle unless stalled
// depends on trpd_pkg
`default_nettype none

module trpd_core import trpd_pkg::*; #(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    input  wire logic [DATA_W-1:0] i_in_byte,
    output logic                   o_in_ready,
    input  wire logic              i_out_free,
    output logic                   o_res_valid,
    output t_result                o_res,
    output t_core_stat             o_stat
);

    localparam int PCB = PIXEL_COUNT_BITS;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_RAW    = 2'd2
    } t_phase;

    logic                  r_in_valid;
    logic [DATA_W-1:0]     r_in_byte;
    t_phase                r_phase,       n_phase;
    logic [COUNT_W-1:0]    r_packet_left, n_packet_left;
    logic [BYTE_IDX_W-1:0] r_byte_idx,    n_byte_idx;
    logic [GATHER_W-1:0]   r_gather,      n_gather;
    logic [PCB-1:0]        r_pixels_left, n_pixels_left;
    logic                  r_finished,    n_finished;

    logic                  fire;
    logic [BPP_W-1:0]      eff_bpp;
    logic                  last_byte;
    logic [PIXEL_W-1:0]    acc;
    logic [PCB-1:0]        load_left;
    logic [PCB-1:0]        left_after;
    logic [COUNT_W-1:0]    count;
    logic                  emit;

    // saturate the pixel total into the counter width
    if (PCB >= PIXEL_TOTAL_W) begin : g_load_wide
        assign load_left = PCB'(i_cfg.pixel_total);
    end else begin : g_load_narrow
        assign load_left = (|i_cfg.pixel_total[PIXEL_TOTAL_W-1:PCB]) ? '1
                                                                       : i_cfg.pixel_total[PCB-1:0];
    end

    assign fire       = r_in_valid & i_out_free & ~i_cfg.restart;
    assign o_in_ready = ~r_in_valid | fire;

    always_comb begin
        if (i_cfg.bytes_per_pixel == '0) begin
            eff_bpp = BPP_MIN;
        end else if (i_cfg.bytes_per_pixel > BPP_MAX) begin
            eff_bpp = BPP_MAX;
        end else begin
            eff_bpp = i_cfg.bytes_per_pixel;
        end
    end

    assign last_byte = ({1'b0, r_byte_idx} + 3'd1) >= eff_bpp;
    assign acc = {8'd0, r_gather} | ({24'd0, r_in_byte} << {r_byte_idx, 3'b000});
    assign left_after = r_pixels_left - PCB'(count);

    always_comb begin
        n_phase       = r_phase;
        n_packet_left = r_packet_left;
        n_byte_idx    = r_byte_idx;
        n_gather      = r_gather;
        n_pixels_left = r_pixels_left;
        n_finished    = r_finished;
        emit          = 1'b0;
        count         = COUNT_W'(1);

        if (i_cfg.restart) begin
            n_phase       = PH_HEADER;
            n_packet_left = '0;
            n_byte_idx    = '0;
            n_gather      = '0;
            n_pixels_left = load_left;
            n_finished    = (load_left == '0);
        end else if (fire && !r_finished) begin
            if (i_cfg.rle_mode && r_phase == PH_HEADER) begin
                if (r_in_byte < RUN_THRESHOLD) begin
                    n_packet_left = r_in_byte + 8'd1;
                    n_phase       = PH_RAW;
                end else begin
                    n_packet_left = r_in_byte - RUN_BIAS;
                    n_phase       = PH_RUN;
                end
                n_byte_idx = '0;
                n_gather   = '0;
            end else if (!last_byte) begin
                n_byte_idx = r_byte_idx + 2'd1;
                n_gather   = acc[GATHER_W-1:0];
            end else begin
                n_byte_idx = '0;
                n_gather   = '0;
                emit       = 1'b1;
                if (i_cfg.rle_mode) begin
                    unique case (r_phase)
                        PH_RUN: begin
                            // clip the run to the pixels still missing
                            if (PCB'(r_packet_left) > r_pixels_left) begin
                                count = r_pixels_left[COUNT_W-1:0];
                            end else begin
                                count = r_packet_left;
                            end
                            n_packet_left = '0;
                            n_phase       = PH_HEADER;
                        end
                        PH_RAW: begin
                            n_packet_left = r_packet_left - 8'd1;
                            if (r_packet_left == 8'd1) begin
                                n_phase = PH_HEADER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                n_pixels_left = left_after;
                if (left_after == '0) begin
                    n_finished = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_phase       <= PH_HEADER;
            r_packet_left <= '0;
            r_byte_idx    <= '0;
            r_gather      <= '0;
            r_pixels_left <= PCB'(PIXEL_TOTAL_RST);
            r_finished    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_phase       <= n_phase;
            r_packet_left <= n_packet_left;
            r_byte_idx    <= n_byte_idx;
            r_gather      <= n_gather;
            r_pixels_left <= n_pixels_left;
            r_finished    <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign o_res_valid        = emit;
    assign o_res.pixel_value  = acc;
    assign o_res.repeat_count = count;
    assign o_res.image_done   = (left_after == '0);

    assign o_stat.finished         = r_finished;
    assign o_stat.left_zero        = (r_pixels_left == '0);
    assign o_stat.phase_header     = (r_phase == PH_HEADER);
    assign o_stat.packet_left_zero = (r_packet_left == '0);

endmodule

`default_nettype wire

// ----- src/trpd_out_reg.sv -----
// result register on the master side, frees when the word is taken
// depends on trpd_pkg
`default_nettype none

module trpd_out_reg import trpd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- src/tga_rle_pixel_decoder.sv -----
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  i_s_tdata: data_byte
// m         out  o_m_tvalid/i_m_tready  o_m_tdata: pixel_value, repeat_count; o_m_tlast: image_done
// apb       in   psel/penable/pwrite    regs at 0x0 rle_mode, 0x4 bytes_per_pixel, 0x8 pixel_total
//
// one byte per cycle sustained while m does not stall; a byte passes through
// the input register, then decode into the result register
// the decode state loop (packet phase, byte index, pixel count) is combinational between its registers
// reset is synchronous active low and leaves rle mode, 4 bytes per pixel, 1 pixel
// a write to a mapped register restarts decoding in the cycle after; stalls on m back up through s
// depends on trpd_pkg, trpd_cfg_regs, trpd_core, trpd_out_reg, tga_rle_pixel_decoder_macros.svh
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder import trpd_pkg::*; #(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [DATA_W-1:0]             i_s_tdata,   // data_byte
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [PIXEL_W+COUNT_W-1:0]         o_m_tdata,   // pixel_value, repeat_count
    output logic                               o_m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_W-1:0]         paddr,
    input  wire logic [APB_DATA_W-1:0]         pwdata,
    output logic      [APB_DATA_W-1:0]         prdata,
    output logic                               pready
);

    t_cfg       cfg;
    t_result    core_res;
    t_result    out_res;
    t_core_stat stat;
    logic       core_res_valid;
    logic       out_free;

    trpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trpd_core #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_tvalid),
        .i_in_byte   (i_s_tdata),
        .o_in_ready  (o_s_tready),
        .i_out_free  (out_free),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .o_stat      (stat)
    );

    trpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (core_res_valid),
        .i_res       (core_res),
        .o_free      (out_free),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = {out_res.repeat_count, out_res.pixel_value};
    assign o_m_tlast = out_res.image_done;

    `TRPD_ASSERT_IMPLY(a_finished_matches_count, i_clk, i_rst_n, 1'b1, stat.finished == stat.left_zero)
    `TRPD_ASSERT_NEXT(a_restart_loads_total, i_clk, i_rst_n, cfg.restart, stat.finished == ($past(cfg.pixel_total) == '0))
    `TRPD_ASSERT_IMPLY(a_header_has_no_packet, i_clk, i_rst_n, stat.phase_header, stat.packet_left_zero)
    `TRPD_ASSERT_IMPLY(a_count_nonzero, i_clk, i_rst_n, core_res_valid, core_res.repeat_count != '0)

endmodule

`default_nettype wire

// ----- tb/tga_rle_pixel_decoder_tb.sv -----
// self-checking testbench for tga_rle_pixel_decoder: byte stream in, pixels with repeat counts out
// an internal decoder model predicts every pixel word; apb writes set mode, bytes per pixel, total
// depends on trpd_pkg and the tga_rle_pixel_decoder rtl
`default_nettype none

module tga_rle_pixel_decoder_tb;
    import trpd_pkg::*;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int SETTLE_CYCLES = 6;
    localparam int END_LIMIT     = 5000;
    localparam int RUN_LIMIT     = 2000000;

    localparam logic [APB_ADDR_W-1:0] ADDR_MODE  = {REG_RLE_MODE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_BPP   = {REG_BPP, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_TOTAL = {REG_PIXEL_TOTAL, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 4'hC;

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        RUN_VALUE,
        RAW_PIXELS
    } t_pkt_phase;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_style;

    class pixel_ledger;
        logic                     rle;
        logic [BPP_W-1:0]         bpp;
        logic [PIXEL_TOTAL_W-1:0] total;
        t_pkt_phase               phase;
        logic [COUNT_W-1:0]       left;
        logic [BYTE_IDX_W-1:0]    idx;
        logic [GATHER_W-1:0]      acc;
        logic [PIXEL_TOTAL_W-1:0] pixels_left;
        bit                       done;
        t_result                  due[$];
        int                       errors;

        task flag(input string what);
            errors++;
            if (errors <= 100)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void restart_image();
            phase       = AWAIT_HEADER;
            left        = '0;
            idx         = '0;
            acc         = '0;
            pixels_left = total;
            done        = (total == 0);
        endfunction

        function void reset_regs();
            rle   = RLE_MODE_RST;
            bpp   = BPP_RST;
            total = PIXEL_TOTAL_RST;
            restart_image();
        endfunction

        function void apply_reg(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
            case (addr[APB_ADDR_W-1:2])
                REG_RLE_MODE:    rle = data[0];
                REG_BPP:         bpp = data[BPP_W-1:0];
                REG_PIXEL_TOTAL: total = data[PIXEL_TOTAL_W-1:0];
                default:         return;
            endcase
            restart_image();
        endfunction

        function logic [BPP_W-1:0] eff_bpp();
            if (bpp == 0)
                return BPP_MIN;
            if (bpp > BPP_MAX)
                return BPP_MAX;
            return bpp;
        endfunction

        function bit gather_byte(input logic [DATA_W-1:0] b, output logic [PIXEL_W-1:0] pix);
            logic [PIXEL_W-1:0] merged;
            merged = {8'h00, acc} | ({24'h000000, b} << {idx, 3'b000});
            pix = merged;
            if ({1'b0, idx} + 3'd1 >= eff_bpp()) begin
                idx = '0;
                acc = '0;
                return 1'b1;
            end
            idx = idx + 2'd1;
            acc = merged[GATHER_W-1:0];
            return 1'b0;
        endfunction

        function void post(input logic [PIXEL_W-1:0] pix, input logic [COUNT_W-1:0] n);
            t_result r;
            pixels_left = pixels_left - n;
            if (pixels_left == 0)
                done = 1'b1;
            r.pixel_value  = pix;
            r.repeat_count = n;
            r.image_done   = done;
            due.push_back(r);
        endfunction

        // returns 1 when the byte takes part in decoding
        function bit note_byte(input logic [DATA_W-1:0] b);
            logic [PIXEL_W-1:0] pix;
            logic [COUNT_W-1:0] n;
            if (done)
                return 1'b0;
            if (!rle) begin
                if (gather_byte(b, pix))
                    post(pix, 8'd1);
                return 1'b1;
            end
            if (phase == AWAIT_HEADER) begin
                if (b < RUN_THRESHOLD) begin
                    left  = b + 8'd1;
                    phase = RAW_PIXELS;
                end else begin
                    left  = b - RUN_BIAS;
                    phase = RUN_VALUE;
                end
                idx = '0;
                acc = '0;
                return 1'b1;
            end
            if (!gather_byte(b, pix))
                return 1'b1;
            if (phase == RUN_VALUE) begin
                n = left;
                if (n > pixels_left)
                    n = pixels_left[COUNT_W-1:0];
                left  = '0;
                phase = AWAIT_HEADER;
                post(pix, n);
            end else begin
                left = left - 8'd1;
                if (left == 0)
                    phase = AWAIT_HEADER;
                post(pix, 8'd1);
            end
            return 1'b1;
        endfunction

        task check_pixel(input logic [PIXEL_W+COUNT_W-1:0] data, input logic last);
            t_result want;
            if (due.size() == 0) begin
                flag($sformatf("unexpected word %h last %b", data, last));
                return;
            end
            want = due.pop_front();
            if (data[PIXEL_W-1:0] !== want.pixel_value)
                flag($sformatf("pixel_value %h, want %h",
                               data[PIXEL_W-1:0], want.pixel_value));
            if (data[PIXEL_W +: COUNT_W] !== want.repeat_count)
                flag($sformatf("repeat_count %0d, want %0d",
                               data[PIXEL_W +: COUNT_W], want.repeat_count));
            if (last !== want.image_done)
                flag($sformatf("image_done %b, want %b", last, want.image_done));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    logic [DATA_W-1:0]         s_data = '0;
    logic                      m_ready = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    wire                       s_ready;
    wire                       m_valid;
    wire [PIXEL_W+COUNT_W-1:0] m_data;
    wire                       m_last;
    wire [APB_DATA_W-1:0]      prdata;
    wire                       pready;

    pixel_ledger  ledger = new();
    int           burst_left = 0;
    int           bytes_used = 0;
    int           ready_span = 0;
    t_ready_style ready_style = READY_ALWAYS;

    tga_rle_pixel_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),    // data_byte
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),    // pixel_value, repeat_count
        .o_m_tlast  (m_last),    // image_done
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (ready_span == 0) begin
            ready_style = t_ready_style'($urandom_range(0, 3));
            ready_span  = $urandom_range(20, 300);
        end
        ready_span--;
        case (ready_style)
            READY_ALWAYS:  m_ready <= 1'b1;
            READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
            default:       m_ready <= (ready_span % 3 != 0);
        endcase
    end

    // handshake signals are stable from the falling edge to the next rising edge
    always @(negedge clk) begin
        if (rst_n && m_valid && m_ready)
            ledger.check_pixel(m_data, m_last);
    end

    task automatic push_byte(input logic [DATA_W-1:0] b);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= b;
        do begin
            @(negedge clk);
            taken = s_ready;
            @(posedge clk);
        end while (!taken);
        if (ledger.note_byte(b))
            bytes_used++;
    endtask

    task automatic push_seq(input logic [DATA_W-1:0] seq[$]);
        foreach (seq[k])
            push_byte(seq[k]);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.apply_reg(addr, data);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (ledger.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_image(input logic mode, input logic [BPP_W-1:0] bpp,
                             input logic [PIXEL_TOTAL_W-1:0] total);
        apb_write(ADDR_MODE, {31'd0, mode});
        apb_write(ADDR_BPP, {29'd0, bpp});
        apb_write(ADDR_TOTAL, {8'd0, total});
    endtask

    function automatic logic [DATA_W-1:0] pick_pixel_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return DATA_W'($urandom_range(0, 255));
    endfunction

    task automatic send_image(input int cap, input bit noisy);
        int sent;
        int n;
        int r;
        logic [DATA_W-1:0] hdr;
        sent = 0;
        if (!ledger.rle || noisy) begin
            while (!ledger.done && sent < cap) begin
                push_byte(pick_pixel_byte());
                sent++;
            end
            return;
        end
        while (!ledger.done && sent < cap) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                hdr = DATA_W'($urandom_range(0, 7));
            else if (r < 7)
                hdr = DATA_W'($urandom_range(128, 135));
            else if (r == 7)
                case ($urandom_range(0, 3))
                    0:       hdr = 8'h00;
                    1:       hdr = 8'h7F;
                    2:       hdr = 8'h80;
                    default: hdr = 8'hFF;
                endcase
            else
                hdr = DATA_W'($urandom_range(0, 255));
            push_byte(hdr);
            sent++;
            n = (hdr < RUN_THRESHOLD) ? (int'(hdr) + 1) * ledger.eff_bpp() : ledger.eff_bpp();
            for (int k = 0; k < n && !ledger.done && sent < cap; k++) begin
                push_byte(pick_pixel_byte());
                sent++;
            end
        end
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("tga_rle_pixel_decoder_tb failed");
        $finish;
    end

    initial begin
        logic                     mode;
        logic [BPP_W-1:0]         bpp;
        logic [PIXEL_TOTAL_W-1:0] total;
        int                       pick;
        int                       cap;
        bit                       noisy;
        int                       wait_cyc;

        ledger.reset_regs();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: raw packet of 128 clipped to a single pixel, then a stray byte
        push_seq('{8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF});

        // longest run, then a run clipped to what is left
        settle();
        set_image(1'b1, 3'd1, 24'd130);
        push_seq('{8'hFF, 8'hAA, 8'hFF, 8'h55});

        // zero bytes per pixel acts as one
        settle();
        set_image(1'b1, 3'd0, 24'd2);
        push_seq('{8'h00, 8'hFF, 8'h80, 8'h01});

        // uncompressed, oversized bytes per pixel acts as four
        settle();
        set_image(1'b0, 3'd7, 24'd1);
        push_seq('{8'hFF, 8'h00, 8'hFF, 8'h00});

        // empty image ignores everything
        settle();
        set_image(1'b1, 3'd2, 24'd0);
        push_byte(8'h80);

        // unmapped register write must not restart a half gathered pixel
        settle();
        set_image(1'b1, 3'd2, 24'hFFFFFF);
        push_seq('{8'h01, 8'h11});
        settle();
        apb_write(ADDR_SPARE, $urandom);
        push_byte(8'h22);

        bytes_used = 0;
        while (bytes_used < RANDOM_ITEMS) begin
            mode = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 19) < 17) begin
                bpp = BPP_W'($urandom_range(1, 4));
            end else begin
                pick = $urandom_range(4, 7);
                bpp = (pick == 4) ? 3'd0 : BPP_W'(pick);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                total = PIXEL_TOTAL_W'($urandom_range(1, 24));
            else if (pick < 80)
                total = PIXEL_TOTAL_W'($urandom_range(25, 200));
            else if (pick < 88)
                total = PIXEL_TOTAL_W'($urandom_range(201, 5000));
            else if (pick < 93)
                total = PIXEL_TOTAL_W'($urandom_range(0, 24'hFFFFFF));
            else if (pick < 96)
                total = 24'hFFFFFF;
            else if (pick < 98)
                total = 24'd0;
            else
                total = 24'd1;

            settle();
            if ($urandom_range(0, 11) == 0)
                apb_write(ADDR_SPARE, $urandom);
            set_image(mode, bpp, total);

            cap = (total > 300 || $urandom_range(0, 7) == 0) ? $urandom_range(1, 80)
                                                              : 1000000;
            noisy = ($urandom_range(0, 9) == 0);
            send_image(cap, noisy);
            if (ledger.done)
                repeat ($urandom_range(0, 3)) push_byte(DATA_W'($urandom_range(0, 255)));
        end

        s_valid <= 1'b0;
        for (wait_cyc = 0; ledger.due.size() != 0 && wait_cyc < END_LIMIT; wait_cyc++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.due.size() != 0)
            ledger.flag($sformatf("%0d results never arrived", ledger.due.size()));

        if (ledger.errors == 0)
            $display("tga_rle_pixel_decoder_tb passed");
        else
            $display("tga_rle_pixel_decoder_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- tga_rle_pixel_decoder.f -----
+incdir+src
src/trpd_pkg.sv
src/trpd_cfg_regs.sv
src/trpd_core.sv
src/trpd_out_reg.sv
src/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_tb.sv
